FILE: rtl/core/lbnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbnp_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_INTENSITY_GAIN = 3'd0;
  localparam logic [2:0] REG_RANGE_MIN      = 3'd1;
  localparam logic [2:0] REG_RANGE_MAX      = 3'd2;
  localparam logic [2:0] REG_PIXEL_SCALE    = 3'd3;
  localparam logic [2:0] REG_ORIGIN_X       = 3'd4;
  localparam logic [2:0] REG_ORIGIN_Y       = 3'd5;
  localparam logic [2:0] REG_ANGLE_START    = 3'd6;
  localparam logic [2:0] REG_ANGLE_STEP     = 3'd7;

  // One square root cell resolves one root bit; the radicand is range << 32.
  localparam int SQ_STEPS = 24;
  // Cells that still consume radicand bits from the range itself.
  localparam int SQ_RANGE_PAIRS = 8;

  // Sine polynomial coefficients, Q30.
  localparam logic [31:0] SIN_C0 = 32'd1686629713;
  localparam logic [31:0] SIN_C1 = 32'd693598669;
  localparam logic [31:0] SIN_C2 = 32'd85569306;
  localparam logic [31:0] SIN_C3 = 32'd5026996;
  localparam logic [30:0] SIN_C4 = 31'd172272;

  localparam int SIN_LAT = 7;

  typedef struct packed {
    logic [25:0] rem;
    logic [23:0] root;
    logic [15:0] range_mm;
  } sq_cell_t;

endpackage

`default_nettype wire

FILE: rtl/core/lidar_beam_normalize_project_unit.sv
// Per-beam intensity normalization and image projection of a laser scan.
// Input channel (in_valid/in_ready) carries one beam per transaction:
// range_mm, raw_intensity and beam_index. Output channel (out_valid/out_ready)
// returns one result per beam, in order: norm_intensity, in_range, pos_x, pos_y.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register per
// cycle and must only be used while no beam is in flight.
// The square root is a chain of 24 cells, one root bit each, followed by two
// multiply stages and a rounding stage; the projection path runs alongside and
// is delayed to match.
// Throughput is one beam per cycle while the receiver takes results.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; empty stages do not hold the pipeline back.
// Reset clears all in-flight transactions and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module lidar_beam_normalize_project_unit #(
  parameter int MAX_BEAMS = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        range_mm,
  input  wire logic [15:0]        raw_intensity,
  input  wire logic [10:0]        beam_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              norm_intensity,
  output logic                    in_range,
  output logic signed [21:0]      pos_x,
  output logic signed [21:0]      pos_y
);

  import lbnp_pkg::*;

  localparam int LAT = SQ_STEPS + 3;
  localparam int PROJ_STAGES = SIN_LAT + 3;

  logic [23:0] intensity_gain;
  logic [15:0] range_min, range_max, pixel_scale;
  logic [20:0] origin_x, origin_y;
  logic [23:0] angle_start, angle_step;

  logic [LAT-1:0] vld;
  logic           en;

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_gain <= 24'd21391;
      range_min      <= 16'd100;
      range_max      <= 16'd3000;
      pixel_scale    <= 16'd4915;
      origin_x       <= 21'd5120;
      origin_y       <= 21'd5120;
      angle_start    <= 24'd8388608;
      angle_step     <= 24'd11651;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INTENSITY_GAIN: intensity_gain <= cfg_data;
        REG_RANGE_MIN:      range_min      <= cfg_data[15:0];
        REG_RANGE_MAX:      range_max      <= cfg_data[15:0];
        REG_PIXEL_SCALE:    pixel_scale    <= cfg_data[15:0];
        REG_ORIGIN_X:       origin_x       <= cfg_data[20:0];
        REG_ORIGIN_Y:       origin_y       <= cfg_data[20:0];
        REG_ANGLE_START:    angle_start    <= cfg_data;
        REG_ANGLE_STEP:     angle_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stages advance together; a bubble at the end never blocks the pipe.
  assign en       = !vld[LAT-1] || out_ready;
  assign in_ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[LAT-1];

  // Range window flag; the beam index must also be below MAX_BEAMS.
  logic win;
  assign win = (range_mm > range_min) && (range_mm < range_max) &&
               (int'(beam_index) < MAX_BEAMS);

  lbnp_delay #(.W(1), .N(LAT)) u_win_dly (
    .clk(clk), .en(en), .d(win), .q(in_range)
  );

  // Square root chain.
  sq_cell_t chain [SQ_STEPS+1];
  assign chain[0] = '{rem: '0, root: '0, range_mm: range_mm};

  genvar gi;
  generate
    for (gi = 0; gi < SQ_STEPS; gi++) begin : g_sq
      lbnp_sqrt_cell #(.IDX(gi)) u_cell (
        .clk(clk), .en(en), .din(chain[gi]), .dout(chain[gi+1])
      );
    end
  endgenerate

  logic [15:0] inten_d;
  lbnp_delay #(.W(16), .N(SQ_STEPS)) u_inten_dly (
    .clk(clk), .en(en), .d(raw_intensity), .q(inten_d)
  );

  logic [39:0] ir;
  logic [51:0] ph, pl;
  logic [63:0] p_sum;
  logic [25:0] n_rnd;

  assign p_sum = {ph, 12'd0} + 64'(pl);
  assign n_rnd = (26'(p_sum[63:39]) + 26'd1) >> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      ir <= inten_d * chain[SQ_STEPS].root;
      ph <= ir * intensity_gain[23:12];
      pl <= ir * intensity_gain[11:0];
      norm_intensity <= (n_rnd > 26'd255) ? 8'd255 : n_rnd[7:0];
    end
  end

  // Projection path.
  logic [23:0] ang;
  logic [31:0] rs, rs_d;

  always_ff @(posedge clk) begin
    if (en) begin
      ang <= 24'(angle_start + 24'(angle_step * beam_index));
      rs  <= range_mm * pixel_scale;
    end
  end

  logic [14:0] mag_s, mag_c;
  logic        neg_s, neg_c;

  lbnp_sine u_sin (
    .clk(clk), .en(en), .angle(ang), .mag(mag_s), .neg(neg_s)
  );
  lbnp_sine u_cos (
    .clk(clk), .en(en), .angle(24'(ang + 24'd4194304)), .mag(mag_c), .neg(neg_c)
  );

  lbnp_delay #(.W(32), .N(SIN_LAT)) u_rs_dly (
    .clk(clk), .en(en), .d(rs), .q(rs_d)
  );

  logic [46:0] mx, my;
  logic        nx, ny;
  logic [47:0] rx, ry;
  logic [21:0] ax, ay;
  logic [21:0] px, py;

  assign rx = 48'(mx) + 48'(64'd1 << 26);
  assign ry = 48'(my) + 48'(64'd1 << 26);
  assign ax = nx ? 22'(-{1'b0, rx[47:27]}) : {1'b0, rx[47:27]};
  assign ay = ny ? 22'(-{1'b0, ry[47:27]}) : {1'b0, ry[47:27]};

  always_ff @(posedge clk) begin
    if (en) begin
      mx <= rs_d * mag_s;
      my <= rs_d * mag_c;
      nx <= neg_s;
      ny <= neg_c;
      px <= ax + {origin_x[20], origin_x};
      py <= ay + {origin_y[20], origin_y};
    end
  end

  logic [21:0] px_d, py_d;
  lbnp_delay #(.W(22), .N(LAT-PROJ_STAGES)) u_px_dly (
    .clk(clk), .en(en), .d(px), .q(px_d)
  );
  lbnp_delay #(.W(22), .N(LAT-PROJ_STAGES)) u_py_dly (
    .clk(clk), .en(en), .d(py), .q(py_d)
  );

  assign pos_x = px_d;
  assign pos_y = py_d;

endmodule

`default_nettype wire

FILE: rtl/core/lbnp_delay.sv
`timescale 1ns / 1ps
`default_nettype none

module lbnp_delay #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] line [N];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < N; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[N-1];

endmodule

`default_nettype wire

FILE: rtl/core/lbnp_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lbnp_sqrt_cell #(
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire lbnp_pkg::sq_cell_t din,
  output lbnp_pkg::sq_cell_t      dout
);

  import lbnp_pkg::*;

  logic [1:0]  pair;
  logic [27:0] trial;
  logic [27:0] sub;

  // The lower 32 radicand bits are zero, so later cells shift in zeros.
  generate
    if (IDX < SQ_RANGE_PAIRS) begin : g_pair
      assign pair = din.range_mm[15-2*IDX -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end
  endgenerate

  assign trial = {din.rem, pair};
  assign sub   = {2'b00, din.root, 2'b01};

  always_ff @(posedge clk) begin
    if (en) begin
      dout.range_mm <= din.range_mm;
      if (trial >= sub) begin
        dout.rem  <= 26'(trial - sub);
        dout.root <= {din.root[22:0], 1'b1};
      end else begin
        dout.rem  <= trial[25:0];
        dout.root <= {din.root[22:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lbnp_sine.sv
`timescale 1ns / 1ps
`default_nettype none

module lbnp_sine (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [23:0] angle,
  output logic      [14:0] mag,
  output logic             neg
);

  import lbnp_pkg::*;

  logic [22:0] t1, t2, t3, t4, t5, t6;
  logic        n1, n2, n3, n4, n5, n6;
  logic [30:0] u2, u3, u4, u5;
  logic [30:0] r3, r4, r5, r6;
  logic [22:0] t_fold;
  logic [45:0] sq;
  logic [61:0] p3, p4, p5, p6;
  logic [53:0] fin;
  logic [16:0] s_rnd;

  // Odd quadrants run the quarter wave backward.
  assign t_fold = angle[22] ? 23'(23'd4194304 - {1'b0, angle[21:0]}) : {1'b0, angle[21:0]};
  assign sq     = t1 * t1;
  assign p3     = u2 * SIN_C4;
  assign p4     = u3 * r3;
  assign p5     = u4 * r4;
  assign p6     = u5 * r5;
  assign fin    = t6 * r6 + (54'd1 << 36);
  assign s_rnd  = fin[53:37];

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= t_fold;  n1 <= angle[23];
      t2 <= t1;      n2 <= n1;  u2 <= sq[44:14];
      t3 <= t2;      n3 <= n2;  u3 <= u2;
      r3 <= 31'(SIN_C3 - 32'(p3[61:30]));
      t4 <= t3;      n4 <= n3;  u4 <= u3;
      r4 <= 31'(SIN_C2 - 32'(p4[61:30]));
      t5 <= t4;      n5 <= n4;  u5 <= u4;
      r5 <= 31'(SIN_C1 - 32'(p5[61:30]));
      t6 <= t5;      n6 <= n5;
      r6 <= 31'(SIN_C0 - 32'(p6[61:30]));
      mag <= (s_rnd > 17'd32767) ? 15'd32767 : s_rnd[14:0];
      neg <= n6;
    end
  end

endmodule

`default_nettype wire
